>>> src/brf_pkg.sv
package brf_pkg;

  // Default ring size in byte slots; one slot always stays empty.
  localparam int DEPTH_DEF = 256;

  // Answer of a read that finds the ring empty.
  localparam logic [7:0] EMPTY_READ_VALUE = 8'hFF;

  // Largest fill level the result field can show.
  localparam int FILL_SAT = 255;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_DISCARD = 2'd2,
    OP_FLUSH   = 2'd3
  } op_t;

  typedef enum logic {
    CTL_IDLE = 1'b0,
    CTL_HOLD = 1'b1
  } ctl_state_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic accept;   // an input transaction completes at this edge
  } ctl_cmd_t;

endpackage

>>> src/brf_in_if.sv
interface brf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] data_byte;
  logic [8:0] remove_count;

  modport source (output valid, output opcode, output data_byte, output remove_count,
                  input ready);
  modport sink (input valid, input opcode, input data_byte, input remove_count,
                output ready);
endinterface

>>> src/brf_out_if.sv
interface brf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       accepted;
  logic [8:0] discarded;
  logic [7:0] fill_level;
  logic       full_res;

  modport source (output valid, output read_byte, output accepted, output discarded,
                  output fill_level, output full_res, input ready);
  modport sink (input valid, input read_byte, input accepted, input discarded,
                input fill_level, input full_res, output ready);
endinterface

>>> src/byte_ring_fifo_unit.sv
// The result of an accepted input transaction appears in the cycle after it is accepted.
// Throughput: one transaction per cycle while the result side keeps taking results.
// Read data comes straight from the registered read port of the byte store RAM.
// Reset (rst_n low, synchronous) empties the ring and the result register.
// The byte store itself is not cleared; it holds undefined data until written.
module byte_ring_fifo_unit #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  brf_in_if.sink    in_ch,
  brf_out_if.source out_ch
);

  // Fill level reported when the ring holds its maximum, after saturation.
  localparam logic [7:0] FILL_FULL =
    (DEPTH - 1 > brf_pkg::FILL_SAT) ? 8'(brf_pkg::FILL_SAT) : 8'(DEPTH - 1);

  brf_pkg::ctl_cmd_t cmd;

  // The controller owns the handshake. It holds one result at a time and lets
  // the next input transaction in during the same cycle the held result leaves,
  // so a steady stream passes at one transaction per cycle while results are taken.
  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // The datapath keeps the read and write pointers, the byte store and the
  // result register. All pointer arithmetic wraps modulo DEPTH with an explicit
  // compare against DEPTH, so DEPTH need not be a power of two. A read of the
  // oldest byte is issued to the RAM at the accept edge and its data appears
  // on the result port together with the rest of the result.
  brf_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .opcode       (in_ch.opcode),
    .data_byte    (in_ch.data_byte),
    .remove_count (in_ch.remove_count),
    .read_byte    (out_ch.read_byte),
    .accepted     (out_ch.accepted),
    .discarded    (out_ch.discarded),
    .fill_level   (out_ch.fill_level),
    .full_res     (out_ch.full_res)
  );

`ifndef SYNTHESIS
  // Every accepted transaction leaves a result behind it.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> out_ch.valid)
    else $error("no result after an accepted transaction");

  // A full ring always reports the largest fill level.
  a_full_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.full_res) |-> (out_ch.fill_level == FILL_FULL))
    else $error("full flag without maximum fill level");

  // A discard never reports an accepted byte.
  a_discard_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.discarded != 9'd0)) |-> !out_ch.accepted)
    else $error("discard result marked accepted");

  // An accepted result never carries a discard count.
  a_empty_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.accepted) |-> (out_ch.discarded == 9'd0))
    else $error("accepted result with discard count");
`endif

endmodule

>>> src/brf_ram.sv
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/brf_ctrl.sv
module brf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output brf_pkg::ctl_cmd_t cmd
);

  brf_pkg::ctl_state_t state_r, state_nxt;
  logic                take;

  // A new item may enter when the result register is empty or is being emptied.
  assign take = in_valid && ((state_r == brf_pkg::CTL_IDLE) || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      brf_pkg::CTL_IDLE: begin
        if (in_valid) state_nxt = brf_pkg::CTL_HOLD;
      end
      brf_pkg::CTL_HOLD: begin
        if (out_ready && !in_valid) state_nxt = brf_pkg::CTL_IDLE;
      end
      default: state_nxt = brf_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    cmd.accept = take;
    case (state_r)
      brf_pkg::CTL_IDLE: begin
        in_ready = 1'b1;
      end
      brf_pkg::CTL_HOLD: begin
        in_ready  = out_ready;
        out_valid = 1'b1;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brf_pkg::CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/brf_datapath.sv
module brf_datapath #(
  parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  brf_pkg::ctl_cmd_t cmd,
  input  logic [1:0]        opcode,
  input  logic [7:0]        data_byte,
  input  logic [8:0]        remove_count,
  output logic [7:0]        read_byte,
  output logic              accepted,
  output logic [8:0]        discarded,
  output logic [7:0]        fill_level,
  output logic              full_res
);

  localparam int PW = $clog2(DEPTH);
  localparam int SW = ((PW > 9) ? PW : 9) + 1;
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [SW-1:0] SAT_S    = SW'(brf_pkg::FILL_SAT);

  logic [PW-1:0] rp_r, rp_nxt, wp_r, wp_nxt;
  logic [PW-1:0] held, wp_inc, rp_inc, rp_adv, fill_nxt;
  logic [SW-1:0] held_s, cnt_s, sum_s, fill_s;
  logic          is_full, ram_we, ram_re;
  logic [7:0]    ram_q;
  brf_pkg::op_t  op;

  logic          use_ram_r, use_ram_nxt;
  logic [7:0]    rd_const_r, rd_const_nxt;
  logic          acc_r, acc_nxt;
  logic [8:0]    disc_r, disc_nxt;
  logic [7:0]    fill_r, fill_out;
  logic          full_r;

  assign op = brf_pkg::op_t'(opcode);

  always_comb begin
    if (wp_r >= rp_r) begin
      held = wp_r - rp_r;
    end else begin
      held = PW'(SW'(wp_r) + DEPTH_S - SW'(rp_r));
    end
  end

  assign wp_inc  = (wp_r == LAST_PTR) ? '0 : wp_r + 1'b1;
  assign rp_inc  = (rp_r == LAST_PTR) ? '0 : rp_r + 1'b1;
  assign is_full = (rp_r == wp_inc);
  assign held_s  = SW'(held);
  assign cnt_s   = SW'(remove_count);
  assign sum_s   = SW'(rp_r) + cnt_s;
  assign rp_adv  = (sum_s >= DEPTH_S) ? PW'(sum_s - DEPTH_S) : PW'(sum_s);

  always_comb begin
    rp_nxt       = rp_r;
    wp_nxt       = wp_r;
    fill_nxt     = held;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    use_ram_nxt  = 1'b0;
    rd_const_nxt = 8'd0;
    acc_nxt      = 1'b0;
    disc_nxt     = 9'd0;
    case (op)
      brf_pkg::OP_WRITE: begin
        if (!is_full) begin
          ram_we   = cmd.accept;
          wp_nxt   = wp_inc;
          acc_nxt  = 1'b1;
          fill_nxt = held + 1'b1;
        end
      end
      brf_pkg::OP_READ: begin
        if (held != '0) begin
          ram_re      = cmd.accept;
          rp_nxt      = rp_inc;
          use_ram_nxt = 1'b1;
          acc_nxt     = 1'b1;
          fill_nxt    = held - 1'b1;
        end else begin
          rd_const_nxt = brf_pkg::EMPTY_READ_VALUE;
        end
      end
      brf_pkg::OP_DISCARD: begin
        if (cnt_s >= held_s) begin
          rp_nxt   = '0;
          wp_nxt   = '0;
          disc_nxt = held_s[8:0];
          fill_nxt = '0;
        end else begin
          rp_nxt   = rp_adv;
          disc_nxt = remove_count;
          fill_nxt = PW'(held_s - cnt_s);
        end
      end
      brf_pkg::OP_FLUSH: begin
        rp_nxt   = '0;
        wp_nxt   = '0;
        fill_nxt = '0;
      end
      default: begin
        rp_nxt   = '0;
        wp_nxt   = '0;
        fill_nxt = '0;
      end
    endcase
  end

  assign fill_s   = SW'(fill_nxt);
  assign fill_out = (fill_s > SAT_S) ? 8'hFF : fill_s[7:0];

  brf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (data_byte),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0;
      wp_r <= '0;
    end else if (cmd.accept) begin
      rp_r <= rp_nxt;
      wp_r <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      use_ram_r  <= use_ram_nxt;
      rd_const_r <= rd_const_nxt;
      acc_r      <= acc_nxt;
      disc_r     <= disc_nxt;
      fill_r     <= fill_out;
      full_r     <= (fill_nxt == LAST_PTR);
    end
  end

  // The RAM output only changes on a read, which always reloads the result.
  assign read_byte  = use_ram_r ? ram_q : rd_const_r;
  assign accepted   = acc_r;
  assign discarded  = disc_r;
  assign fill_level = fill_r;
  assign full_res   = full_r;

endmodule
